### rtl/core/bmf_pkg.sv
package bmf_pkg;

  // table geometry
  localparam int USERS  = 4096;
  localparam int MOVIES = 2048;
  localparam int RANK   = 32;

  // item field widths
  localparam int CMD_W    = 2;
  localparam int UI_W     = 12;
  localparam int MI_W     = 11;
  localparam int RATING_W = 3;
  localparam int TGT_W    = 2;
  localparam int COMP_W   = 5;
  localparam int VAL_W    = 16;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ETA_W     = 16;
  localparam int REG_W     = 16;
  localparam int MU_W      = 15;

  localparam logic [ETA_W-1:0] ETA_RESET = 16'd66;
  localparam logic [REG_W-1:0] REG_RESET = 16'd655;
  localparam logic [MU_W-1:0]  MU_RESET  = 15'd14746;

  localparam logic [CFG_IDX_W-1:0] CFG_ETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MU  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TRAIN   = 2'd1,
    CMD_PREDICT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_UF = 2'd0,
    TGT_MF = 2'd1,
    TGT_UB = 2'd2,
    TGT_MB = 2'd3
  } tgt_t;

  // memory geometry
  localparam int UF_DEPTH = USERS * RANK;
  localparam int MF_DEPTH = MOVIES * RANK;
  localparam int UF_AW    = (UF_DEPTH > 1) ? $clog2(UF_DEPTH) : 1;
  localparam int MF_AW    = (MF_DEPTH > 1) ? $clog2(MF_DEPTH) : 1;
  localparam int UB_AW    = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int MB_AW    = (MOVIES > 1) ? $clog2(MOVIES) : 1;
  localparam int K_W      = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int KC_W     = $clog2(RANK + 1);

  // shared multiply-accumulate unit
  localparam int A_W    = 37;
  localparam int B_W    = 17;
  localparam int P_W    = A_W + B_W;
  localparam int MAC_W  = 56;
  localparam int PRED_W = MAC_W - 12;
  localparam int D_W    = MAC_W - 32;
  localparam int Q12_ONE = 4096;

  // index reduction for tables smaller than the index fields
  localparam bit NEED_WRAP = (USERS < (1 << UI_W)) || (MOVIES < (1 << MI_W)) ||
                             (RANK < (1 << COMP_W));
  localparam int RED_W     = 33;
  localparam int J_W       = 4;
  localparam int WRAP_STEPS = UI_W;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [MAC_W-1:0] x);
    logic [MAC_W-VAL_W:0] top;
    top = x[MAC_W-1:VAL_W-1];
    if ((&top) || (~|top)) begin
      return x[VAL_W-1:0];
    end else if (x[MAC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  // new value of a table element: x minus the rounded step, saturated
  function automatic logic signed [VAL_W-1:0] apply_step(input logic signed [VAL_W-1:0] x,
                                                         input logic signed [D_W-1:0] d);
    logic signed [MAC_W-1:0] diff;
    diff = {{(MAC_W-VAL_W){x[VAL_W-1]}}, x} - {{(MAC_W-D_W){d[D_W-1]}}, d};
    return sat_val(diff);
  endfunction

  // one restoring step of x mod n
  function automatic logic [RED_W-1:0] wrap_step(input logic [RED_W-1:0] x,
                                                 input logic [RED_W-1:0] n,
                                                 input logic [J_W-1:0] j);
    logic [RED_W-1:0] m;
    m = n << j;
    if (x >= m) begin
      return x - m;
    end else begin
      return x;
    end
  endfunction

endpackage

### rtl/core/bmf_in_if.sv
interface bmf_in_if;
  logic                             valid;
  logic                             ready;
  logic [bmf_pkg::CMD_W-1:0]        command;
  logic [bmf_pkg::UI_W-1:0]         user_index;
  logic [bmf_pkg::MI_W-1:0]         movie_index;
  logic [bmf_pkg::RATING_W-1:0]     rating;
  logic [bmf_pkg::TGT_W-1:0]        load_target;
  logic [bmf_pkg::COMP_W-1:0]       load_component;
  logic signed [bmf_pkg::VAL_W-1:0] load_value;

  modport source (
    output valid, command, user_index, movie_index, rating, load_target,
           load_component, load_value,
    input  ready
  );

  modport sink (
    input  valid, command, user_index, movie_index, rating, load_target,
           load_component, load_value,
    output ready
  );
endinterface

### rtl/core/bmf_out_if.sv
interface bmf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bmf_pkg::VAL_W-1:0] prediction;
  logic signed [bmf_pkg::VAL_W-1:0] residual;

  modport source (
    output valid, prediction, residual,
    input  ready
  );

  modport sink (
    input  valid, prediction, residual,
    output ready
  );
endinterface

### rtl/core/bmf_ram.sv
module bmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/biased_matrix_factor_sgd.sv
// Biased matrix factorization trainer. A load item writes one element of the
// user/movie factor tables or bias tables; tables must be loaded before use.
// A predict item returns mu + dot(u,v) + user bias + movie bias (Q4.12,
// saturated); a train item also returns the residual and applies one SGD step
// to both factor rows and both biases. Every data product goes through one
// 37x17 multiply-accumulate unit, and each factor component needs four
// products plus a read and two writes, so timing is set by that unit and the
// factor memory ports. When the tables are smaller than the index fields,
// every item also goes through index reduction. The block takes one item at
// a time; a finished result sits in the output register, so the next item
// can start while it waits to be taken.
module biased_matrix_factor_sgd (
  input  logic                               clk,
  input  logic                               rst_n,
  bmf_in_if.sink                             in_if,
  bmf_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]          cfg_data
);

  localparam int VAL_W  = bmf_pkg::VAL_W;
  localparam int A_W    = bmf_pkg::A_W;
  localparam int B_W    = bmf_pkg::B_W;
  localparam int P_W    = bmf_pkg::P_W;
  localparam int MAC_W  = bmf_pkg::MAC_W;
  localparam int PRED_W = bmf_pkg::PRED_W;
  localparam int D_W    = bmf_pkg::D_W;
  localparam int KC_W   = bmf_pkg::KC_W;
  localparam int K_W    = bmf_pkg::K_W;
  localparam int UF_AW  = bmf_pkg::UF_AW;
  localparam int MF_AW  = bmf_pkg::MF_AW;
  localparam int UB_AW  = bmf_pkg::UB_AW;
  localparam int MB_AW  = bmf_pkg::MB_AW;
  localparam int J_W    = bmf_pkg::J_W;
  localparam int RED_W  = bmf_pkg::RED_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_WRAP = 12'b000000000010,
    S_BASE = 12'b000000000100,
    S_LOAD = 12'b000000001000,
    S_DOT  = 12'b000000010000,
    S_BIAS = 12'b000000100000,
    S_PRED = 12'b000001000000,
    S_RES  = 12'b000010000000,
    S_COEF = 12'b000100000000,
    S_UPD  = 12'b001000000000,
    S_BUPD = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    MAC_HOLD  = 2'd0,
    MAC_CLEAR = 2'd1,
    MAC_ADD   = 2'd2
  } mac_op_t;

  // control
  state_t                   state_r, state_nxt;
  logic [2:0]               sub_r, sub_nxt;
  logic [KC_W-1:0]          k_r, k_nxt;
  logic [J_W-1:0]           j_r, j_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [bmf_pkg::ETA_W-1:0] eta_r;
  logic [bmf_pkg::REG_W-1:0] reg_r;
  logic [bmf_pkg::MU_W-1:0]  mu_r;

  // item and working registers
  bmf_pkg::cmd_t             cmd_r, cmd_nxt;
  bmf_pkg::tgt_t             tgt_r, tgt_nxt;
  logic [bmf_pkg::UI_W-1:0]  ui_r, ui_nxt;
  logic [bmf_pkg::MI_W-1:0]  mi_r, mi_nxt;
  logic [bmf_pkg::RATING_W-1:0] rating_r, rating_nxt;
  logic [bmf_pkg::COMP_W-1:0] comp_r, comp_nxt;
  logic signed [VAL_W-1:0]   lval_r, lval_nxt;
  logic [UF_AW-1:0]          ubase_r, ubase_nxt;
  logic [MF_AW-1:0]          mbase_r, mbase_nxt;
  logic signed [MAC_W-1:0]   acc_r, acc_nxt;
  logic signed [PRED_W-1:0]  pred_r, pred_nxt;
  logic signed [VAL_W-1:0]   s_r, s_nxt;
  logic signed [VAL_W-1:0]   wpred_r, wpred_nxt;
  logic signed [VAL_W-1:0]   wres_r, wres_nxt;
  logic signed [A_W-1:0]     er_r, er_nxt;
  logic signed [A_W-1:0]     es16n_r, es16n_nxt;
  logic signed [VAL_W-1:0]   uo_r, uo_nxt;
  logic signed [VAL_W-1:0]   vo_r, vo_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic signed [VAL_W-1:0]   out_pred_r, out_pred_nxt;
  logic signed [VAL_W-1:0]   out_res_r, out_res_nxt;

  // shared multiply-accumulate
  mac_op_t                   mac_op;
  logic signed [A_W-1:0]     mac_a;
  logic signed [B_W-1:0]     mac_b;
  logic signed [P_W-1:0]     prod;
  logic signed [MAC_W-1:0]   prod_ext;

  // memories
  logic                      uf_we, mf_we, ub_we, mb_we;
  logic [UF_AW-1:0]          uf_addr;
  logic [MF_AW-1:0]          mf_addr;
  logic [UB_AW-1:0]          ub_addr;
  logic [MB_AW-1:0]          mb_addr;
  logic [VAL_W-1:0]          uf_wdata, mf_wdata, ub_wdata, mb_wdata;
  logic [VAL_W-1:0]          uf_rdata, mf_rdata, ub_rdata, mb_rdata;

  // datapath helpers
  logic [K_W-1:0]            k_idx, comp_k;
  logic signed [MAC_W-1:0]   acc_rnd12, acc_rnd32;
  logic signed [MAC_W-1:0]   pred_ext, res_w, es_neg;
  logic signed [17:0]        bias_sum;
  logic                      in_ready;

  assign k_idx  = k_r[K_W-1:0];
  assign comp_k = K_W'(comp_r);

  assign uf_addr = ubase_r + UF_AW'((state_r == S_LOAD) ? comp_k : k_idx);
  assign mf_addr = mbase_r + MF_AW'((state_r == S_LOAD) ? comp_k : k_idx);
  assign ub_addr = UB_AW'(ui_r);
  assign mb_addr = MB_AW'(mi_r);

  assign prod     = mac_a * mac_b;
  assign prod_ext = {{(MAC_W-P_W){prod[P_W-1]}}, prod};

  // round half up to Q.12 and to the update scale
  assign acc_rnd12 = acc_r + {{(MAC_W-12){1'b0}}, 12'h800};
  assign acc_rnd32 = acc_r + {{(MAC_W-32){1'b0}}, 1'b1, 31'b0};

  assign pred_ext = {{(MAC_W-PRED_W){pred_r[PRED_W-1]}}, pred_r};
  assign res_w    = {{(MAC_W-15){1'b0}}, rating_r, 12'b0} - pred_ext;
  assign es_neg   = '0 - (acc_r <<< 4);
  assign bias_sum = {3'b0, mu_r} + {{2{ub_rdata[VAL_W-1]}}, ub_rdata}
                  + {{2{mb_rdata[VAL_W-1]}}, mb_rdata};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r + 3'd1;
    k_nxt         = k_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    ui_nxt        = ui_r;
    mi_nxt        = mi_r;
    rating_nxt    = rating_r;
    comp_nxt      = comp_r;
    lval_nxt      = lval_r;
    ubase_nxt     = ubase_r;
    mbase_nxt     = mbase_r;
    pred_nxt      = pred_r;
    s_nxt         = s_r;
    wpred_nxt     = wpred_r;
    wres_nxt      = wres_r;
    er_nxt        = er_r;
    es16n_nxt     = es16n_r;
    uo_nxt        = uo_r;
    vo_nxt        = vo_r;
    d_nxt         = d_r;
    out_pred_nxt  = out_pred_r;
    out_res_nxt   = out_res_r;
    mac_op        = MAC_HOLD;
    mac_a         = '0;
    mac_b         = '0;
    uf_we         = 1'b0;
    mf_we         = 1'b0;
    ub_we         = 1'b0;
    mb_we         = 1'b0;
    uf_wdata      = lval_r;
    mf_wdata      = lval_r;
    ub_wdata      = lval_r;
    mb_wdata      = lval_r;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt    = bmf_pkg::cmd_t'(in_if.command);
          tgt_nxt    = bmf_pkg::tgt_t'(in_if.load_target);
          ui_nxt     = in_if.user_index;
          mi_nxt     = in_if.movie_index;
          rating_nxt = in_if.rating;
          comp_nxt   = in_if.load_component;
          lval_nxt   = in_if.load_value;
          j_nxt      = J_W'(bmf_pkg::WRAP_STEPS - 1);
          state_nxt  = bmf_pkg::NEED_WRAP ? S_WRAP : S_BASE;
        end
      end
      S_WRAP: begin
        ui_nxt   = bmf_pkg::UI_W'(bmf_pkg::wrap_step(RED_W'(ui_r),
                                                      RED_W'(bmf_pkg::USERS), j_r));
        mi_nxt   = bmf_pkg::MI_W'(bmf_pkg::wrap_step(RED_W'(mi_r),
                                                      RED_W'(bmf_pkg::MOVIES), j_r));
        comp_nxt = bmf_pkg::COMP_W'(bmf_pkg::wrap_step(RED_W'(comp_r),
                                                        RED_W'(bmf_pkg::RANK), j_r));
        j_nxt    = j_r - J_W'(1);
        if (j_r == '0) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        ubase_nxt = UF_AW'(ui_r) * UF_AW'(bmf_pkg::RANK);
        mbase_nxt = MF_AW'(mi_r) * MF_AW'(bmf_pkg::RANK);
        k_nxt     = '0;
        wpred_nxt = '0;
        wres_nxt  = '0;
        case (cmd_r)
          bmf_pkg::CMD_LOAD:    state_nxt = S_LOAD;
          bmf_pkg::CMD_TRAIN:   state_nxt = S_DOT;
          bmf_pkg::CMD_PREDICT: state_nxt = S_DOT;
          default:              state_nxt = S_FIN;
        endcase
      end
      S_LOAD: begin
        case (tgt_r)
          bmf_pkg::TGT_UF: uf_we = 1'b1;
          bmf_pkg::TGT_MF: mf_we = 1'b1;
          bmf_pkg::TGT_UB: ub_we = 1'b1;
          default:         mb_we = 1'b1;
        endcase
        state_nxt = S_FIN;
      end
      S_DOT: begin
        // read data comes from the RAM output register, so it trails the address
        mac_a = {{(A_W-VAL_W){uf_rdata[VAL_W-1]}}, uf_rdata};
        mac_b = {{(B_W-VAL_W){mf_rdata[VAL_W-1]}}, mf_rdata};
        if (k_r == KC_W'(1)) begin
          mac_op = MAC_CLEAR;
        end else if (k_r != '0) begin
          mac_op = MAC_ADD;
        end
        if (k_r == KC_W'(bmf_pkg::RANK)) begin
          state_nxt = S_BIAS;
        end else begin
          k_nxt = k_r + KC_W'(1);
        end
      end
      S_BIAS: begin
        mac_op    = MAC_ADD;
        mac_a     = {{(A_W-18){bias_sum[17]}}, bias_sum};
        mac_b     = B_W'(bmf_pkg::Q12_ONE);
        state_nxt = S_PRED;
      end
      S_PRED: begin
        pred_nxt  = acc_rnd12[MAC_W-1:12];
        state_nxt = S_RES;
      end
      S_RES: begin
        wpred_nxt = bmf_pkg::sat_val(pred_ext);
        sub_nxt   = '0;
        if (cmd_r == bmf_pkg::CMD_TRAIN) begin
          s_nxt     = bmf_pkg::sat_val(res_w);
          wres_nxt  = bmf_pkg::sat_val(res_w);
          state_nxt = S_COEF;
        end else begin
          wres_nxt  = '0;
          state_nxt = S_FIN;
        end
      end
      S_COEF: begin
        // eta*reg and -16*eta*s, shared by every step of this item
        mac_a = {{(A_W-bmf_pkg::ETA_W){1'b0}}, eta_r};
        case (sub_r)
          3'd0: begin
            mac_op = MAC_CLEAR;
            mac_b  = {1'b0, reg_r};
          end
          3'd1: begin
            er_nxt = acc_r[A_W-1:0];
            mac_op = MAC_CLEAR;
            mac_b  = {s_r[VAL_W-1], s_r};
          end
          default: begin
            es16n_nxt = es_neg[A_W-1:0];
            k_nxt     = '0;
            sub_nxt   = '0;
            state_nxt = S_UPD;
          end
        endcase
      end
      S_UPD: begin
        case (sub_r)
          3'd0: ;
          3'd1: begin
            uo_nxt = uf_rdata;
            vo_nxt = mf_rdata;
            mac_op = MAC_CLEAR;
            mac_a  = er_r;
            mac_b  = {uf_rdata[VAL_W-1], uf_rdata};
          end
          3'd2: begin
            mac_op = MAC_ADD;
            mac_a  = es16n_r;
            mac_b  = {vo_r[VAL_W-1], vo_r};
          end
          3'd3: begin
            d_nxt  = acc_rnd32[MAC_W-1:32];
            mac_op = MAC_CLEAR;
            mac_a  = er_r;
            mac_b  = {vo_r[VAL_W-1], vo_r};
          end
          3'd4: begin
            uf_we    = 1'b1;
            uf_wdata = bmf_pkg::apply_step(uo_r, d_r);
            mac_op   = MAC_ADD;
            mac_a    = es16n_r;
            mac_b    = {uo_r[VAL_W-1], uo_r};
          end
          3'd5: begin
            d_nxt = acc_rnd32[MAC_W-1:32];
          end
          default: begin
            mf_we    = 1'b1;
            mf_wdata = bmf_pkg::apply_step(vo_r, d_r);
            sub_nxt  = '0;
            if (k_r == KC_W'(bmf_pkg::RANK - 1)) begin
              state_nxt = S_BUPD;
            end else begin
              k_nxt = k_r + KC_W'(1);
            end
          end
        endcase
      end
      S_BUPD: begin
        // bias reads stay valid: their rows have not been written yet
        case (sub_r)
          3'd0: begin
            mac_op = MAC_CLEAR;
            mac_a  = er_r;
            mac_b  = {ub_rdata[VAL_W-1], ub_rdata};
          end
          3'd1: begin
            mac_op = MAC_ADD;
            mac_a  = es16n_r;
            mac_b  = B_W'(bmf_pkg::Q12_ONE);
          end
          3'd2: begin
            d_nxt  = acc_rnd32[MAC_W-1:32];
            mac_op = MAC_CLEAR;
            mac_a  = er_r;
            mac_b  = {mb_rdata[VAL_W-1], mb_rdata};
          end
          3'd3: begin
            ub_we    = 1'b1;
            ub_wdata = bmf_pkg::apply_step(ub_rdata, d_r);
            mac_op   = MAC_ADD;
            mac_a    = es16n_r;
            mac_b    = B_W'(bmf_pkg::Q12_ONE);
          end
          3'd4: begin
            d_nxt = acc_rnd32[MAC_W-1:32];
          end
          default: begin
            mb_we     = 1'b1;
            mb_wdata  = bmf_pkg::apply_step(mb_rdata, d_r);
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = wpred_r;
          out_res_nxt   = wres_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    case (mac_op)
      MAC_CLEAR: acc_nxt = prod_ext;
      MAC_ADD:   acc_nxt = acc_r + prod_ext;
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= '0;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      eta_r       <= bmf_pkg::ETA_RESET;
      reg_r       <= bmf_pkg::REG_RESET;
      mu_r        <= bmf_pkg::MU_RESET;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bmf_pkg::CFG_ETA: eta_r <= cfg_data;
          bmf_pkg::CFG_REG: reg_r <= cfg_data;
          bmf_pkg::CFG_MU:  mu_r  <= cfg_data[bmf_pkg::MU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tgt_r      <= tgt_nxt;
    ui_r       <= ui_nxt;
    mi_r       <= mi_nxt;
    rating_r   <= rating_nxt;
    comp_r     <= comp_nxt;
    lval_r     <= lval_nxt;
    ubase_r    <= ubase_nxt;
    mbase_r    <= mbase_nxt;
    acc_r      <= acc_nxt;
    pred_r     <= pred_nxt;
    s_r        <= s_nxt;
    wpred_r    <= wpred_nxt;
    wres_r     <= wres_nxt;
    er_r       <= er_nxt;
    es16n_r    <= es16n_nxt;
    uo_r       <= uo_nxt;
    vo_r       <= vo_nxt;
    d_r        <= d_nxt;
    out_pred_r <= out_pred_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.prediction = out_pred_r;
  assign out_if.residual   = out_res_r;

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(bmf_pkg::UF_DEPTH)) u_uf_ram (
    .clk   (clk),
    .we    (uf_we),
    .waddr (uf_addr),
    .wdata (uf_wdata),
    .raddr (uf_addr),
    .rdata (uf_rdata)
  );

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(bmf_pkg::MF_DEPTH)) u_mf_ram (
    .clk   (clk),
    .we    (mf_we),
    .waddr (mf_addr),
    .wdata (mf_wdata),
    .raddr (mf_addr),
    .rdata (mf_rdata)
  );

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(bmf_pkg::USERS)) u_ub_ram (
    .clk   (clk),
    .we    (ub_we),
    .waddr (ub_addr),
    .wdata (ub_wdata),
    .raddr (ub_addr),
    .rdata (ub_rdata)
  );

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(bmf_pkg::MOVIES)) u_mb_ram (
    .clk   (clk),
    .we    (mb_we),
    .waddr (mb_addr),
    .wdata (mb_wdata),
    .raddr (mb_addr),
    .rdata (mb_rdata)
  );

endmodule

### test/biased_matrix_factor_sgd_tb.sv
module biased_matrix_factor_sgd_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmf_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 135;
  localparam int PHASES       = 6;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 1500;

  typedef struct {
    cmd_t                    cmd;
    logic [UI_W-1:0]         user;
    logic [MI_W-1:0]         movie;
    logic [RATING_W-1:0]     rating;
    tgt_t                    target;
    logic [COMP_W-1:0]       comp;
    logic signed [VAL_W-1:0] value;
  } rating_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] prediction;
    logic signed [VAL_W-1:0] residual;
  } rating_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bmf_in_if  req_ch ();
  bmf_out_if score_ch ();

  biased_matrix_factor_sgd uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (score_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the tables and registers
  logic signed [VAL_W-1:0] user_vec  [UF_DEPTH];
  logic signed [VAL_W-1:0] movie_vec [MF_DEPTH];
  logic signed [VAL_W-1:0] user_off  [USERS];
  logic signed [VAL_W-1:0] movie_off [MOVIES];
  logic [ETA_W-1:0] eta_q;
  logic [REG_W-1:0] reg_q;
  logic [MU_W-1:0]  mu_q;

  rating_req_t  pending_reqs[$];
  rating_resp_t expected_scores[$];
  int user_rows[$];
  int movie_rows[$];

  int in_offered   = 0;
  int in_taken     = 0;
  int results_seen = 0;
  int errors       = 0;
  int cycles       = 0;

  function automatic longint round_q(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp16(input longint x);
    if (x > 32767) return 16'h7FFF;
    if (x < -32768) return 16'h8000;
    return x[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] nudge(input logic signed [VAL_W-1:0] x,
                                                    input longint grad);
    return clamp16(longint'(x) - round_q(longint'(eta_q) * grad, 32));
  endfunction

  // expected result of one item, updating the shadow tables as the block would
  function automatic rating_resp_t score_request(input rating_req_t q);
    rating_resp_t r;
    longint acc, pred;
    logic signed [VAL_W-1:0] s, uo, vo, a, b;
    int ui, mi, k, urow, mrow, j;
    ui = int'(q.user) % USERS;
    mi = int'(q.movie) % MOVIES;
    k = int'(q.comp) % RANK;
    urow = ui * RANK;
    mrow = mi * RANK;
    r.prediction = '0;
    r.residual = '0;
    case (q.cmd)
      CMD_LOAD: begin
        case (q.target)
          TGT_UF: user_vec[urow + k] = q.value;
          TGT_MF: movie_vec[mrow + k] = q.value;
          TGT_UB: user_off[ui] = q.value;
          default: movie_off[mi] = q.value;
        endcase
      end
      CMD_TRAIN, CMD_PREDICT: begin
        acc = 0;
        for (j = 0; j < RANK; j++)
          acc += longint'(user_vec[urow + j]) * longint'(movie_vec[mrow + j]);
        acc += (longint'(mu_q) + longint'(user_off[ui]) + longint'(movie_off[mi])) * 4096;
        pred = round_q(acc, 12);
        r.prediction = clamp16(pred);
        if (q.cmd == CMD_TRAIN) begin
          // residual from the unsaturated prediction, then saturated
          s = clamp16(longint'(q.rating) * 4096 - pred);
          r.residual = s;
          for (j = 0; j < RANK; j++) begin
            uo = user_vec[urow + j];
            vo = movie_vec[mrow + j];
            user_vec[urow + j] = nudge(uo, longint'(reg_q) * uo - longint'(vo) * s * 16);
            movie_vec[mrow + j] = nudge(vo, longint'(reg_q) * vo - longint'(uo) * s * 16);
          end
          a = user_off[ui];
          b = movie_off[mi];
          user_off[ui] = nudge(a, longint'(reg_q) * a - longint'(s) * 65536);
          movie_off[mi] = nudge(b, longint'(reg_q) * b - longint'(s) * 65536);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input int n);
    int r;
    if (n >= 500 && n < 650) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic queue_req(input cmd_t c, input int u, input int m, input int rt,
                           input tgt_t t, input int k, input int v);
    rating_req_t q;
    q.cmd = c;
    q.user = UI_W'(u);
    q.movie = MI_W'(m);
    q.rating = RATING_W'(rt);
    q.target = t;
    q.comp = COMP_W'(k);
    q.value = VAL_W'(v);
    pending_reqs = {pending_reqs, q};
  endtask

  // fill a whole factor row and its bias so train and predict may read it
  task automatic load_row(input bit for_user, input int row);
    int k;
    for (k = 0; k < RANK; k++)
      queue_req(CMD_LOAD, for_user ? row : 0, for_user ? 0 : row, 0,
                for_user ? TGT_UF : TGT_MF, k, int'($urandom_range(0, 4095)) - 2048);
    queue_req(CMD_LOAD, for_user ? row : 0, for_user ? 0 : row, 0,
              for_user ? TGT_UB : TGT_MB, 0, int'($urandom_range(0, 4095)) - 2048);
    if (for_user) user_rows = {user_rows, row};
    else movie_rows = {movie_rows, row};
  endtask

  task automatic queue_random_req();
    rating_req_t q;
    int pick;
    pick = $urandom_range(0, 99);
    q.cmd = CMD_NONE;
    q.user = UI_W'($urandom_range(0, USERS - 1));
    q.movie = MI_W'($urandom_range(0, MOVIES - 1));
    q.rating = RATING_W'($urandom_range(0, 7));
    q.target = tgt_t'($urandom_range(0, 3));
    q.comp = COMP_W'($urandom_range(0, RANK - 1));
    q.value = VAL_W'($urandom);
    if (pick < 62) begin
      q.cmd = (pick < 45) ? CMD_TRAIN : CMD_PREDICT;
      q.user = UI_W'(user_rows[$urandom_range(0, user_rows.size() - 1)]);
      q.movie = MI_W'(movie_rows[$urandom_range(0, movie_rows.size() - 1)]);
      if ($urandom_range(0, 3) != 0) q.rating = RATING_W'($urandom_range(1, 5));
    end else if (pick < 82) begin
      // rewrite an element of a live row, mostly with a modest value
      q.cmd = CMD_LOAD;
      q.user = UI_W'(user_rows[$urandom_range(0, user_rows.size() - 1)]);
      q.movie = MI_W'(movie_rows[$urandom_range(0, movie_rows.size() - 1)]);
      if ($urandom_range(0, 4) != 0) q.value = 16'($urandom_range(0, 4095)) - 16'd2048;
    end else if (pick < 95) begin
      q.cmd = CMD_LOAD;
    end
    pending_reqs = {pending_reqs, q};
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ETA: eta_q = val;
      CFG_REG: reg_q = val;
      CFG_MU:  mu_q = val[MU_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_rates(input int eta, input int decay, input int mu);
    write_register(CFG_ETA, CFG_W'(eta));
    write_register(CFG_REG, CFG_W'(decay));
    write_register(CFG_MU, CFG_W'(mu));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_taken != in_offered || expected_scores.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  int send_gap = 0;
  rating_req_t cur_req;

  always @(negedge clk) begin
    if (rst_n && !(req_ch.valid && in_taken != in_offered)) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= cur_req.cmd;
        req_ch.user_index <= cur_req.user;
        req_ch.movie_index <= cur_req.movie;
        req_ch.rating <= cur_req.rating;
        req_ch.load_target <= cur_req.target;
        req_ch.load_component <= cur_req.comp;
        req_ch.load_value <= cur_req.value;
        in_offered++;
        send_gap = pick_gap(in_offered);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with one long hold-off to fill the block
  int stall_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        score_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        score_ch.ready <= 1'b1;
        stall_left = pick_gap(results_seen);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rating_req_t  seen;
    rating_resp_t want;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.cmd = cmd_t'(req_ch.command);
        seen.user = req_ch.user_index;
        seen.movie = req_ch.movie_index;
        seen.rating = req_ch.rating;
        seen.target = tgt_t'(req_ch.load_target);
        seen.comp = req_ch.load_component;
        seen.value = req_ch.load_value;
        want = score_request(seen);
        expected_scores = {expected_scores, want};
        in_taken++;
      end
      if (score_ch.valid && score_ch.ready) begin
        results_seen++;
        if (expected_scores.size() == 0) begin
          $display("%0t ns: unexpected item, prediction %0d residual %0d", $time,
                   score_ch.prediction, score_ch.residual);
          errors++;
        end else begin
          want = expected_scores.pop_front();
          if (score_ch.prediction !== want.prediction) begin
            $display("%0t ns: prediction expected %0d, got %0d", $time,
                     want.prediction, score_ch.prediction);
            errors++;
          end
          if (score_ch.residual !== want.residual) begin
            $display("%0t ns: residual expected %0d, got %0d", $time,
                     want.residual, score_ch.residual);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  int eta_set   [PHASES] = '{1200, 65535, 0, 65535, 0, 0};
  int decay_set [PHASES] = '{655, 65535, 0, 0, 65535, 0};
  int mu_set    [PHASES] = '{14746, 20480, 0, 32767, 20480, 0};

  initial begin
    int p, n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ETA;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_LOAD;
    req_ch.user_index = '0;
    req_ch.movie_index = '0;
    req_ch.rating = '0;
    req_ch.load_target = TGT_UF;
    req_ch.load_component = '0;
    req_ch.load_value = '0;
    score_ch.ready = 1'b0;
    eta_q = ETA_RESET;
    reg_q = REG_RESET;
    mu_q = MU_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_row(1'b1, 0);
    load_row(1'b1, USERS - 1);
    load_row(1'b1, $urandom_range(1, USERS - 2));
    load_row(1'b0, 0);
    load_row(1'b0, MOVIES - 1);
    load_row(1'b0, $urandom_range(1, MOVIES - 2));

    // saturation both ways on prediction and residual
    queue_req(CMD_LOAD, 0, 0, 0, TGT_UF, 31, 32767);
    queue_req(CMD_LOAD, 0, 0, 0, TGT_MF, 31, 32767);
    queue_req(CMD_PREDICT, 0, 0, 7, TGT_UF, 0, 0);
    queue_req(CMD_TRAIN, 0, 0, 0, TGT_UF, 0, 0);
    queue_req(CMD_LOAD, 0, 0, 0, TGT_UF, 31, -32768);
    queue_req(CMD_TRAIN, 0, 0, 7, TGT_UF, 0, 0);
    queue_req(CMD_LOAD, 0, 0, 0, TGT_UF, 31, 256);
    queue_req(CMD_LOAD, 0, 0, 0, TGT_MF, 31, -256);
    // bias extremes on the top rows
    queue_req(CMD_LOAD, USERS - 1, 0, 0, TGT_UB, 0, -32768);
    queue_req(CMD_LOAD, 0, MOVIES - 1, 0, TGT_MB, 0, 32767);
    queue_req(CMD_PREDICT, USERS - 1, MOVIES - 1, 0, TGT_UF, 0, 0);
    queue_req(CMD_TRAIN, USERS - 1, MOVIES - 1, 3, TGT_UF, 0, 0);
    queue_req(CMD_LOAD, USERS - 1, 0, 0, TGT_UB, 0, 0);
    queue_req(CMD_LOAD, 0, MOVIES - 1, 0, TGT_MB, 0, 0);
    // load fields on train and rating on predict are don't-care
    queue_req(CMD_TRAIN, USERS - 1, MOVIES - 1, 5, TGT_MB, 31, -1);
    queue_req(CMD_PREDICT, 0, MOVIES - 1, 7, TGT_UB, 17, 12345);
    queue_req(CMD_TRAIN, 0, 0, 1, TGT_UF, 0, 0);
    queue_req(CMD_NONE, USERS - 1, MOVIES - 1, 7, TGT_MB, 31, -1);
    queue_req(CMD_NONE, 0, 0, 0, TGT_UF, 0, 0);
    queue_req(CMD_LOAD, 2730, 1365, 6, TGT_UF, 21, 21845);
    queue_req(CMD_LOAD, 1365, 682, 1, TGT_MF, 10, -21846);
    queue_req(CMD_TRAIN, USERS - 1, 0, 7, TGT_UF, 0, 0);
    queue_req(CMD_PREDICT, user_rows[2], movie_rows[2], 2, TGT_UF, 0, 0);

    // reset register values first
    for (n = 0; n < RANDOM_ITEMS; n++) queue_random_req();
    drain();

    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1)
        set_rates($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 20480));
      else
        set_rates(eta_set[p], decay_set[p], mu_set[p]);
      for (n = 0; n < RANDOM_ITEMS; n++) queue_random_req();
      drain();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
